// File: rtl/i2cseq_pkg.sv
// i2cseq_pkg: beat types and command codes for the I2C command bit sequencer.
// No dependencies; imported by i2cseq_fsm and i2c_command_bit_sequencer.
package i2cseq_pkg;

    localparam logic [7:0] CMD_START   = 8'h00;
    localparam logic [7:0] CMD_STOP    = 8'h20;
    localparam logic [7:0] CMD_RD_NACK = 8'h60;
    localparam logic [7:0] CMD_WR      = 8'h80;
    localparam logic [7:0] CMD_RPT     = 8'hC0;
    localparam logic [7:0] CMD_CFG     = 8'hE0;

    localparam logic [3:0] BYTE_BITS   = 4'd8;
    localparam logic [3:0] BYTE_MSB    = 4'd7;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] tx_byte;
        logic       sda_in;
    } tick_beat_t;

    typedef struct packed {
        logic        drive_valid;
        logic        scl_out;
        logic        sda_out;
        logic        byte_taken;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        unknown_cmd;
        logic [15:0] wait_cycles;
    } drive_beat_t;

endpackage

// File: rtl/i2cseq_fsm.sv
// i2cseq_fsm: command sequencer state machine; one tick per step, result registered.
// Depends on i2cseq_pkg.
module i2cseq_fsm (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  i2cseq_pkg::tick_beat_t   tick,
    output i2cseq_pkg::drive_beat_t  result
);
    import i2cseq_pkg::*;

    typedef enum logic [3:0] {
        S_WAIT_CMD     = 4'd0,
        S_WAIT_RPT_CMD = 4'd1,
        S_WAIT_CFG     = 4'd2,
        S_START0       = 4'd3,
        S_STOP0        = 4'd4,
        S_STOP1        = 4'd5,
        S_WR0          = 4'd6,
        S_WR1          = 4'd7,
        S_WAIT_RPT     = 4'd8
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [15:0] div_reg, div_next;
    logic [7:0]  rleft_reg, rleft_next;
    logic [7:0]  rcmd_reg, rcmd_next;
    logic [15:0] shift_reg, shift_next;
    logic [3:0]  bits_reg, bits_next;
    logic        reading_reg, reading_next;
    logic        last_scl_reg, last_scl_next;
    logic        last_sda_reg, last_sda_next;
    drive_beat_t result_reg, result_next;

    logic        cmd_go;
    logic        cmd_unk_flag;
    logic [7:0]  cmd_code;
    logic [15:0] div_wait;
    logic [15:0] wr_src;
    logic        scl_tog;

    assign div_wait = (div_reg == 16'd0) ? 16'd1 : div_reg;
    assign scl_tog  = ~last_scl_reg;
    assign wr_src   = (bits_reg == BYTE_BITS) ? {8'd0, tick.tx_byte} : shift_reg;

    always_comb
    begin
        state_next    = state_reg;
        div_next      = div_reg;
        rleft_next    = rleft_reg;
        rcmd_next     = rcmd_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        reading_next  = reading_reg;
        last_scl_next = last_scl_reg;
        last_sda_next = last_sda_reg;
        result_next   = '0;
        result_next.wait_cycles = 16'd1;
        cmd_go        = 1'b0;
        cmd_unk_flag  = 1'b0;
        cmd_code      = tick.tx_byte;

        if (reading_reg)
        begin
            last_scl_next       = scl_tog;
            result_next.drive_valid = 1'b1;
            result_next.scl_out = scl_tog;
            result_next.sda_out = 1'b1;
            if (scl_tog)
            begin
                shift_next = {shift_reg[14:0], tick.sda_in};
                bits_next  = bits_reg - 4'd1;
                result_next.wait_cycles = div_wait;
                if (bits_reg == 4'd1)
                begin
                    result_next.rx_valid = 1'b1;
                    result_next.rx_data  = shift_next[7:0];
                    reading_next = 1'b0;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                S_WAIT_RPT_CMD:
                begin
                    if (tick.byte_valid)
                    begin
                        result_next.byte_taken = 1'b1;
                        rcmd_next    = tick.tx_byte;
                        rleft_next   = rleft_reg - 8'd1;
                        cmd_go       = 1'b1;
                        cmd_unk_flag = 1'b1;
                    end
                end
                S_WAIT_CFG:
                begin
                    if (tick.byte_valid)
                    begin
                        result_next.byte_taken = 1'b1;
                        if (bits_reg == 4'd0)
                            shift_next = {tick.tx_byte, 8'd0};
                        else
                        begin
                            div_next   = shift_reg | {8'd0, tick.tx_byte};
                            state_next = S_WAIT_CMD;
                        end
                        bits_next = bits_reg + BYTE_BITS;
                    end
                end
                S_START0:
                begin
                    state_next = S_WAIT_CMD;
                    result_next.drive_valid = 1'b1;
                    result_next.scl_out     = 1'b1;
                    result_next.wait_cycles = div_wait;
                    last_scl_next = 1'b1;
                end
                S_STOP0:
                begin
                    state_next = S_STOP1;
                    result_next.drive_valid = 1'b1;
                    result_next.scl_out     = 1'b1;
                    result_next.wait_cycles = div_wait;
                    last_scl_next = 1'b1;
                end
                S_STOP1:
                begin
                    state_next = S_WAIT_CMD;
                    result_next.drive_valid = 1'b1;
                    result_next.scl_out     = 1'b1;
                    result_next.sda_out     = 1'b1;
                    result_next.wait_cycles = div_wait;
                    last_scl_next = 1'b1;
                end
                S_WR0:
                begin
                    if (bits_reg != BYTE_BITS || tick.byte_valid)
                    begin
                        last_sda_next = wr_src[BYTE_MSB];
                        shift_next    = {wr_src[14:0], 1'b0};
                        bits_next     = bits_reg - 4'd1;
                        state_next    = S_WR1;
                        result_next.drive_valid = 1'b1;
                        result_next.scl_out     = 1'b0;
                        result_next.sda_out     = wr_src[BYTE_MSB];
                        result_next.wait_cycles = div_wait;
                        last_scl_next = 1'b0;
                    end
                end
                S_WR1:
                begin
                    if (bits_reg != 4'd0 || tick.byte_valid)
                    begin
                        if (bits_reg == 4'd0)
                        begin
                            result_next.byte_taken = 1'b1;
                            state_next = S_WAIT_CMD;
                        end
                        else
                            state_next = S_WR0;
                        result_next.drive_valid = 1'b1;
                        result_next.scl_out     = 1'b1;
                        result_next.sda_out     = last_sda_reg;
                        result_next.wait_cycles = div_wait;
                        last_scl_next = 1'b1;
                    end
                end
                S_WAIT_RPT:
                begin
                    if (tick.byte_valid)
                    begin
                        result_next.byte_taken = 1'b1;
                        rleft_next = tick.tx_byte;
                        state_next = S_WAIT_RPT_CMD;
                    end
                end
                default:
                begin
                    state_next = S_WAIT_CMD;
                    if (rleft_reg != 8'd0)
                    begin
                        rleft_next = rleft_reg - 8'd1;
                        cmd_code   = rcmd_reg;
                        cmd_go     = 1'b1;
                    end
                    else if (tick.byte_valid)
                    begin
                        result_next.byte_taken = 1'b1;
                        cmd_go       = 1'b1;
                        cmd_unk_flag = 1'b1;
                    end
                end
            endcase

            if (cmd_go)
            begin
                unique case (cmd_code)
                    CMD_CFG:
                    begin
                        state_next = S_WAIT_CFG;
                        bits_next  = 4'd0;
                    end
                    CMD_START:
                    begin
                        state_next = S_START0;
                        result_next.drive_valid = 1'b1;
                        result_next.scl_out     = 1'b1;
                        result_next.sda_out     = 1'b1;
                        result_next.wait_cycles = div_wait;
                        last_scl_next = 1'b1;
                    end
                    CMD_STOP:
                    begin
                        state_next = S_STOP0;
                        result_next.drive_valid = 1'b1;
                        result_next.wait_cycles = div_wait;
                        last_scl_next = 1'b0;
                    end
                    CMD_WR:
                    begin
                        state_next = S_WR0;
                        bits_next  = BYTE_BITS;
                    end
                    CMD_RD_NACK:
                    begin
                        state_next   = S_WAIT_CMD;
                        reading_next = 1'b1;
                        bits_next    = BYTE_BITS;
                    end
                    CMD_RPT:
                        state_next = S_WAIT_RPT;
                    default:
                        result_next.unknown_cmd = cmd_unk_flag;
                endcase
            end
        end
    end

    // repeat command store has no reset; it is read only after being written
    always_ff @(posedge clk)
    begin
        if (step)
            rcmd_reg <= rcmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_WAIT_CMD;
            div_reg      <= 16'd0;
            rleft_reg    <= 8'd0;
            shift_reg    <= 16'd0;
            bits_reg     <= 4'd0;
            reading_reg  <= 1'b0;
            last_scl_reg <= 1'b1;
            last_sda_reg <= 1'b1;
            result_reg   <= '0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            div_reg      <= div_next;
            rleft_reg    <= rleft_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            reading_reg  <= reading_next;
            last_scl_reg <= last_scl_next;
            last_sda_reg <= last_sda_next;
            result_reg   <= result_next;
        end
    end

    assign result = result_reg;

    a_read_ends_high: assert property (@(posedge clk) disable iff (!rst_n)
        step && reading_reg && result_next.rx_valid |=> !reading_reg && last_scl_reg)
        else $error("read completed without SCL high");

    a_wr_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR1) |-> (bits_reg <= BYTE_MSB))
        else $error("write bit counter out of range in high phase");

    a_rx_only_reading: assert property (@(posedge clk) disable iff (!rst_n)
        step && result_next.rx_valid |-> reading_reg)
        else $error("received byte outside a read");

endmodule

// File: rtl/i2c_command_bit_sequencer.sv
// i2c_command_bit_sequencer: top level; tick channel in, drive/result channel out.
// Depends on i2cseq_pkg and i2cseq_fsm.
//
//   channel | valid     | stall     | beat
//   --------+-----------+-----------+-------------------------------
//   tick in | cmd_valid | cmd_stall | cmd_beat (i2cseq_pkg::tick_beat_t)
//   result  | res_valid | res_stall | res_beat (i2cseq_pkg::drive_beat_t)
//
// One tick per clock while cmd_stall is low; its result is in the output register in the cycle after accept.
// The only throttle is the single output register: cmd_stall is high while a
// result is held and res_stall is high.
// Reset returns the sequencer to wait-for-command with divider 0 and an empty output.
module i2c_command_bit_sequencer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  i2cseq_pkg::tick_beat_t   cmd_beat,
    output logic                     res_valid,
    input  logic                     res_stall,
    output i2cseq_pkg::drive_beat_t  res_beat
);
    import i2cseq_pkg::*;

    logic res_valid_reg, res_valid_next;
    logic step;

    assign cmd_stall      = res_valid_reg && res_stall;
    assign step           = cmd_valid && !cmd_stall;
    assign res_valid_next = step || (res_valid_reg && res_stall);

    i2cseq_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .tick   (cmd_beat),
        .result (res_beat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    assign res_valid = res_valid_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res_valid)
        else $error("accepted tick produced no result");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |-> cmd_stall)
        else $error("tick accepted over a held result");

    a_rx_is_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_beat.rx_valid |-> res_beat.drive_valid && res_beat.scl_out)
        else $error("received byte without SCL high drive");

    a_idle_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_beat.drive_valid |-> !res_beat.scl_out && !res_beat.sda_out
            && res_beat.wait_cycles == 16'd1)
        else $error("undriven tick with line levels or long wait");

    a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_beat.wait_cycles != 16'd0)
        else $error("zero wait");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: feeds bit-period ticks with a command byte stream into the I2C command
// bit sequencer and checks each drive beat against a local predictor of the sequencer.
// Depends on i2cseq_pkg and i2c_command_bit_sequencer.
module testbench;
    import i2cseq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_RPT_CMD,
        SQ_CFG,
        SQ_START,
        SQ_STOP0,
        SQ_STOP1,
        SQ_WR0,
        SQ_WR1,
        SQ_RPT_CNT
    } seq_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    tick_beat_t  cmd_beat = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    drive_beat_t res_beat;

    // predictor state
    seq_state_t  sq = SQ_IDLE;
    logic [15:0] divider = 16'd0;
    logic [7:0]  rpt_left = 8'd0;
    logic [7:0]  rpt_cmd = 8'd0;
    logic [15:0] shreg = 16'd0;
    logic [3:0]  bit_cnt = 4'd0;
    logic        rd_on = 1'b0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;
    drive_beat_t drv_next;

    logic [7:0]  byte_stream[$];
    drive_beat_t expected_drives[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int starve_pct = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int n_checked = 0;
    int n_ticks = 0;
    int n_taken = 0;
    int n_rx = 0;
    int n_unknown = 0;

    i2c_command_bit_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] bit_period();
        return (divider == 16'd0) ? 16'd1 : divider;
    endfunction

    function automatic void drive_bus(input logic scl, input logic sda);
        drv_next.drive_valid = 1'b1;
        drv_next.scl_out = scl;
        drv_next.sda_out = sda;
        drv_next.wait_cycles = bit_period();
        scl_q = scl;
    endfunction

    // returns 0 for an unsupported code
    function automatic logic exec_cmd(input logic [7:0] code);
        case (code)
            CMD_CFG:
            begin
                sq = SQ_CFG;
                bit_cnt = 4'd0;
            end
            CMD_START:
            begin
                sq = SQ_START;
                drive_bus(1'b1, 1'b1);
            end
            CMD_STOP:
            begin
                sq = SQ_STOP0;
                drive_bus(1'b0, 1'b0);
            end
            CMD_WR:
            begin
                sq = SQ_WR0;
                bit_cnt = BYTE_BITS;
            end
            CMD_RD_NACK:
            begin
                sq = SQ_IDLE;
                rd_on = 1'b1;
                bit_cnt = BYTE_BITS;
            end
            CMD_RPT: sq = SQ_RPT_CNT;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic drive_beat_t predict_drive(input tick_beat_t t);
        drv_next = '0;
        drv_next.wait_cycles = 16'd1;
        if (rd_on)
        begin
            // a read owns the bus regardless of the command state
            scl_q = ~scl_q;
            drv_next.drive_valid = 1'b1;
            drv_next.scl_out = scl_q;
            drv_next.sda_out = 1'b1;
            if (scl_q)
            begin
                shreg = {shreg[14:0], t.sda_in};
                bit_cnt = bit_cnt - 4'd1;
                drv_next.wait_cycles = bit_period();
                if (bit_cnt == 4'd0)
                begin
                    drv_next.rx_valid = 1'b1;
                    drv_next.rx_data = shreg[7:0];
                    rd_on = 1'b0;
                end
            end
        end
        else
        begin
            case (sq)
                SQ_RPT_CMD:
                    if (t.byte_valid)
                    begin
                        drv_next.byte_taken = 1'b1;
                        rpt_cmd = t.tx_byte;
                        rpt_left = rpt_left - 8'd1;
                        drv_next.unknown_cmd = !exec_cmd(t.tx_byte);
                    end
                SQ_CFG:
                    if (t.byte_valid)
                    begin
                        drv_next.byte_taken = 1'b1;
                        if (bit_cnt == 4'd0)
                            shreg = {t.tx_byte, 8'h00};
                        else
                        begin
                            divider = shreg | {8'h00, t.tx_byte};
                            sq = SQ_IDLE;
                        end
                        bit_cnt = bit_cnt + BYTE_BITS;
                    end
                SQ_START:
                begin
                    sq = SQ_IDLE;
                    drive_bus(1'b1, 1'b0);
                end
                SQ_STOP0:
                begin
                    sq = SQ_STOP1;
                    drive_bus(1'b1, 1'b0);
                end
                SQ_STOP1:
                begin
                    sq = SQ_IDLE;
                    drive_bus(1'b1, 1'b1);
                end
                SQ_WR0:
                    if (bit_cnt != BYTE_BITS || t.byte_valid)
                    begin
                        if (bit_cnt == BYTE_BITS)
                            shreg = {8'h00, t.tx_byte};
                        sda_q = shreg[BYTE_MSB];
                        shreg = shreg << 1;
                        bit_cnt = bit_cnt - 4'd1;
                        sq = SQ_WR1;
                        drive_bus(1'b0, sda_q);
                    end
                SQ_WR1:
                    if (bit_cnt != 4'd0 || t.byte_valid)
                    begin
                        if (bit_cnt == 4'd0)
                        begin
                            drv_next.byte_taken = 1'b1;
                            sq = SQ_IDLE;
                        end
                        else
                            sq = SQ_WR0;
                        drive_bus(1'b1, sda_q);
                    end
                SQ_RPT_CNT:
                    if (t.byte_valid)
                    begin
                        drv_next.byte_taken = 1'b1;
                        rpt_left = t.tx_byte;
                        sq = SQ_RPT_CMD;
                    end
                default:
                begin
                    sq = SQ_IDLE;
                    if (rpt_left != 8'd0)
                    begin
                        rpt_left = rpt_left - 8'd1;
                        void'(exec_cmd(rpt_cmd));
                    end
                    else if (t.byte_valid)
                    begin
                        drv_next.byte_taken = 1'b1;
                        drv_next.unknown_cmd = !exec_cmd(t.tx_byte);
                    end
                end
            endcase
        end
        return drv_next;
    endfunction

    function automatic string beat_text(input drive_beat_t b);
        return $sformatf("drv=%b scl=%b sda=%b take=%b rxv=%b rx=%02h unk=%b wait=%04h",
                         b.drive_valid, b.scl_out, b.sda_out, b.byte_taken,
                         b.rx_valid, b.rx_data, b.unknown_cmd, b.wait_cycles);
    endfunction

    task automatic send_tick(input tick_beat_t t, output logic taken);
        drive_beat_t d;
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_beat <= t;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        d = predict_drive(t);
        expected_drives.push_back(d);
        taken = d.byte_taken;
        n_ticks++;
        n_taken += d.byte_taken;
        n_rx += d.rx_valid;
        n_unknown += d.unknown_cmd;
    endtask

    task automatic run_ticks(input int count);
        tick_beat_t t;
        logic taken;
        repeat (count)
        begin
            t.byte_valid = (byte_stream.size() != 0) && ($urandom_range(99) >= starve_pct);
            t.tx_byte = t.byte_valid ? byte_stream[0] : 8'($urandom_range(255));
            t.sda_in = 1'($urandom_range(1));
            send_tick(t, taken);
            if (taken)
                void'(byte_stream.pop_front());
        end
    endtask

    // tick until the stream is empty and the sequencer is back at rest
    task automatic finish_commands();
        logic wants_byte;
        while (byte_stream.size() != 0 || rd_on || rpt_left != 8'd0 || sq != SQ_IDLE)
        begin
            wants_byte = !rd_on && (sq == SQ_RPT_CMD || sq == SQ_CFG || sq == SQ_RPT_CNT
                         || (sq == SQ_WR0 && bit_cnt == BYTE_BITS)
                         || (sq == SQ_WR1 && bit_cnt == 4'd0));
            if (byte_stream.size() == 0 && wants_byte)
                byte_stream.push_back(CMD_STOP);
            run_ticks(1);
        end
    endtask

    task automatic queue_random_sequence();
        int pick;
        int reps;
        logic [7:0] code;
        logic [15:0] div_val;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0: div_val = 16'h0000;
                1: div_val = 16'hFFFF;
                2: div_val = 16'($urandom_range(1, 8));
                default: div_val = 16'($urandom_range(16'hFFFF));
            endcase
            byte_stream.push_back(CMD_CFG);
            byte_stream.push_back(div_val[15:8]);
            byte_stream.push_back(div_val[7:0]);
        end
        else if (pick < 25)
            byte_stream.push_back(CMD_START);
        else if (pick < 40)
            byte_stream.push_back(CMD_STOP);
        else if (pick < 60)
        begin
            byte_stream.push_back(CMD_WR);
            case ($urandom_range(5))
                0: byte_stream.push_back(8'h00);
                1: byte_stream.push_back(8'hFF);
                default: byte_stream.push_back(8'($urandom_range(255)));
            endcase
        end
        else if (pick < 75)
            byte_stream.push_back(CMD_RD_NACK);
        else if (pick < 88)
        begin
            reps = $urandom_range(1, 5);
            case ($urandom_range(4))
                0: code = CMD_START;
                1: code = CMD_STOP;
                2: code = CMD_WR;
                3: code = CMD_RD_NACK;
                default: code = CMD_CFG;
            endcase
            byte_stream.push_back(CMD_RPT);
            byte_stream.push_back(8'(reps));
            byte_stream.push_back(code);
            if (code == CMD_WR || code == CMD_CFG)
                repeat ((code == CMD_CFG) ? 2 * reps : reps)
                    byte_stream.push_back(8'($urandom_range(255)));
        end
        else if (pick < 94)
        begin
            do
                code = 8'($urandom_range(255));
            while (code == CMD_START || code == CMD_STOP || code == CMD_RD_NACK
                   || code == CMD_WR || code == CMD_RPT || code == CMD_CFG);
            byte_stream.push_back(code);
        end
        else
            byte_stream.push_back(8'($urandom_range(255)));
    endtask

    task automatic test_bus_and_config();
        run_ticks(1);
        byte_stream = '{CMD_CFG};
        run_ticks(2);
        byte_stream = '{8'hFF, 8'hFF, CMD_START, 8'h01, CMD_STOP};
        finish_commands();
        byte_stream = '{CMD_CFG, 8'h00, 8'h00, CMD_START, CMD_STOP, CMD_CFG, 8'h00, 8'h01};
        finish_commands();
    endtask

    task automatic test_write_read();
        byte_stream = '{CMD_WR};
        run_ticks(2);
        byte_stream = '{8'hFF};
        run_ticks(15);
        // hold back the data byte on the last bit
        starve_pct = 100;
        run_ticks(1);
        starve_pct = 0;
        byte_stream.push_back(CMD_RD_NACK);
        byte_stream.push_back(CMD_WR);
        byte_stream.push_back(8'h00);
        finish_commands();
    endtask

    task automatic test_repeat();
        byte_stream = '{CMD_RPT, 8'd2, CMD_START};
        finish_commands();
        byte_stream = '{CMD_RPT, 8'd2, 8'h33, CMD_STOP};
        finish_commands();
        byte_stream = '{CMD_RPT, 8'd3, CMD_WR, 8'h5A, 8'hC3, 8'h0F};
        finish_commands();
        // count of zero wraps to 256 runs
        idle_pct = 29;
        stall_pct = 29;
        byte_stream = '{CMD_RPT, 8'd0, CMD_START};
        finish_commands();
    endtask

    task automatic test_random();
        starve_pct = 8;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    idle_pct = 29;
                    stall_pct = 29;
                end
            endcase
            repeat (170)
            begin
                if (byte_stream.size() < 4)
                    queue_random_sequence();
                run_ticks(1);
            end
            if (phase == 1)
            begin
                cmd_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_drives.size() != 0);
            end
        end
        finish_commands();
        starve_pct = 0;
    endtask

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : check_drive
        drive_beat_t e;
        logic bad;
        if (rst_n && res_valid === 1'b1 && !res_stall)
        begin
            if (expected_drives.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected drive beat: %s", beat_text(res_beat));
            end
            else
            begin
                e = expected_drives.pop_front();
                n_checked++;
                bad = (res_beat.drive_valid !== e.drive_valid)
                    || (res_beat.scl_out !== e.scl_out)
                    || (res_beat.sda_out !== e.sda_out)
                    || (res_beat.byte_taken !== e.byte_taken)
                    || (res_beat.rx_valid !== e.rx_valid)
                    || (res_beat.rx_data !== e.rx_data)
                    || (res_beat.unknown_cmd !== e.unknown_cmd)
                    || (res_beat.wait_cycles !== e.wait_cycles);
                if (bad)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("drive beat %0d mismatch\n  expected %s\n  actual   %s",
                                 n_checked, beat_text(e), beat_text(res_beat));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bus_and_config();
        test_write_read();
        test_repeat();
        test_random();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_drives.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d ticks sent: %0d stream bytes consumed, %0d bytes read, %0d unknown commands",
                 n_ticks, n_taken, n_rx, n_unknown);
        $display("%0d drive beats checked, %0d failures", n_checked, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
